// File: hw/rtl/cst_pkg.sv
// Shared constants and scan record type for the coalescing signal table.
package cst_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    localparam logic [1:0] OP_INSERT      = 2'd0;
    localparam logic [1:0] OP_EXTRACT     = 2'd1;
    localparam logic [1:0] OP_SYS_EXTRACT = 2'd2;

    localparam logic [2:0] CODE_FREE   = 3'd0;
    localparam logic [2:0] CODE_SYSTEM = 3'h1;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    localparam logic [6:0] LIMIT_RESET = 7'd64;

    typedef struct packed {
        logic        valid;
        logic [1:0]  opcode;
        logic [2:0]  code;
        logic [31:0] sender;
        logic [5:0]  signo;
        logic [31:0] payload;
        logic        filter_enable;
        logic [63:0] filter_mask;
        logic [6:0]  best;
        logic        hit;
        logic [2:0]  hit_code;
        logic [31:0] hit_sender;
        logic [5:0]  hit_signo;
        logic [31:0] hit_payload;
        logic [15:0] hit_count;
    } scan_t;

endpackage

// File: hw/rtl/cst_if.sv
// Request, response and configuration channel interfaces.
interface cst_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [2:0]  code;
    logic [31:0] sender;
    logic [5:0]  signo;
    logic [31:0] payload;
    logic        filter_enable;
    logic [63:0] filter_mask;

    modport source (
        output valid, opcode, code, sender, signo, payload, filter_enable, filter_mask,
        input  ready
    );
    modport sink (
        input  valid, opcode, code, sender, signo, payload, filter_enable, filter_mask,
        output ready
    );
endinterface

interface cst_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [2:0]  out_code;
    logic [31:0] out_sender;
    logic [5:0]  out_signo;
    logic [31:0] out_payload;
    logic [15:0] out_count;

    modport source (
        output valid, status, out_code, out_sender, out_signo, out_payload, out_count,
        input  ready
    );
    modport sink (
        input  valid, status, out_code, out_sender, out_signo, out_payload, out_count,
        output ready
    );
endinterface

interface cst_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] signo_limit;

    modport source (
        output valid, signo_limit,
        input  ready
    );
    modport sink (
        input  valid, signo_limit,
        output ready
    );
endinterface

// File: hw/rtl/cst_cell.sv
// One table entry with its stage of the scan chain.
module cst_cell #(
    parameter int TABLE_DEPTH = cst_pkg::TABLE_DEPTH_DEF,
    parameter int CELL_INDEX  = 0,
    parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cst_pkg::scan_t      scan_in,
    input  logic [IDX_W-1:0]    pos_in,
    output cst_pkg::scan_t      scan_out,
    output logic [IDX_W-1:0]    pos_out,
    input  logic                commit_valid,
    input  logic [IDX_W-1:0]    commit_pos
);
    import cst_pkg::*;

    localparam logic [IDX_W-1:0] MY_INDEX = IDX_W'(CELL_INDEX);

    logic [2:0]       code_reg, code_next;
    logic [31:0]      sender_reg, sender_next;
    logic [5:0]       signo_reg, signo_next;
    logic [31:0]      payload_reg, payload_next;
    logic [15:0]      count_reg, count_next;
    scan_t            scan_reg, scan_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic             ordinary;
    logic             allowed;

    assign ordinary = (code_reg != CODE_FREE) && (code_reg != CODE_SYSTEM);
    assign allowed  = !scan_in.filter_enable ||
                      ((signo_reg != 6'd0) && scan_in.filter_mask[signo_reg - 6'd1]);

    always_comb
    begin
        code_next    = code_reg;
        sender_next  = sender_reg;
        signo_next   = signo_reg;
        payload_next = payload_reg;
        count_next   = count_reg;
        scan_next    = scan_in;
        pos_next     = pos_in;

        if (scan_in.valid) begin
            case (scan_in.opcode)
                OP_INSERT:
                begin
                    if (!scan_in.hit) begin
                        if (code_reg == CODE_FREE) begin
                            code_next     = scan_in.code;
                            sender_next   = scan_in.sender;
                            signo_next    = scan_in.signo;
                            payload_next  = scan_in.payload;
                            count_next    = 16'd1;
                            scan_next.hit = 1'b1;
                        end else if ((code_reg == scan_in.code) &&
                                     (sender_reg == scan_in.sender) &&
                                     (signo_reg == scan_in.signo)) begin
                            if (count_reg != COUNT_MAX) begin
                                count_next = count_reg + 16'd1;
                            end
                            scan_next.hit = 1'b1;
                        end
                    end
                end
                OP_EXTRACT:
                begin
                    if (ordinary && ({1'b0, signo_reg} < scan_in.best) && allowed) begin
                        scan_next.best        = {1'b0, signo_reg};
                        scan_next.hit         = 1'b1;
                        scan_next.hit_code    = code_reg;
                        scan_next.hit_sender  = sender_reg;
                        scan_next.hit_signo   = signo_reg;
                        scan_next.hit_payload = payload_reg;
                        scan_next.hit_count   = count_reg;
                        pos_next              = MY_INDEX;
                    end
                end
                OP_SYS_EXTRACT:
                begin
                    if ((code_reg == CODE_SYSTEM) && (signo_reg == scan_in.signo)) begin
                        scan_next.hit         = 1'b1;
                        scan_next.hit_code    = code_reg;
                        scan_next.hit_sender  = sender_reg;
                        scan_next.hit_signo   = signo_reg;
                        scan_next.hit_payload = payload_reg;
                        scan_next.hit_count   = count_reg;
                        pos_next              = MY_INDEX;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // retire one pending instance of the selected entry
        if (commit_valid && (commit_pos == MY_INDEX)) begin
            if (count_reg <= 16'd1) begin
                count_next = 16'd0;
                code_next  = CODE_FREE;
            end else begin
                count_next = count_reg - 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            code_reg <= CODE_FREE;
            scan_reg <= '0;
        end else begin
            code_reg <= code_next;
            scan_reg <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sender_reg  <= sender_next;
        signo_reg   <= signo_next;
        payload_reg <= payload_next;
        count_reg   <= count_next;
        pos_reg     <= pos_next;
    end

    assign scan_out = scan_reg;
    assign pos_out  = pos_reg;

endmodule

// File: hw/rtl/coalescing_signal_table.sv
// Coalescing pending-signal table: controller and chain of entry cells.
//
//  channel | dir | payload
//  --------+-----+--------------------------------------------------------------
//  req     | in  | opcode, code, sender, signo, payload, filter_enable, filter_mask
//  rsp     | out | status, out_code, out_sender, out_signo, out_payload, out_count
//  cfg     | in  | signo_limit
//
//  A scan record walks the cell chain one entry per cycle, then the result is
//  registered and the chosen entry retired; no new item is taken until then.
//  Reset clears every entry to free and signo_limit to 64; no clearing pass.
//  A stalled rsp holds the finished scan; req stays low until the result moves.
//  cfg is always ready.
module coalescing_signal_table #(
    parameter int TABLE_DEPTH = cst_pkg::TABLE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    cst_req_if.sink       req,
    cst_rsp_if.source     rsp,
    cst_cfg_if.sink       cfg
);
    import cst_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [6:0]       limit_reg;
    scan_t            head_reg;
    scan_t            tail_reg;
    logic [IDX_W-1:0] tail_pos_reg;
    scan_t            chain [TABLE_DEPTH+1];
    logic [IDX_W-1:0] pos_chain [TABLE_DEPTH+1];
    logic [TABLE_DEPTH:0] live;

    logic             rsp_valid_reg;
    logic [1:0]       status_reg;
    logic [2:0]       out_code_reg;
    logic [31:0]      out_sender_reg;
    logic [5:0]       out_signo_reg;
    logic [31:0]      out_payload_reg;
    logic [15:0]      out_count_reg;

    logic             req_xfer;
    logic             rsp_load;
    logic             is_extract;
    logic             commit_valid;

    assign req.ready = (state_reg == S_IDLE);
    assign req_xfer  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign is_extract   = (tail_reg.opcode == OP_EXTRACT) ||
                          (tail_reg.opcode == OP_SYS_EXTRACT);
    assign rsp_load     = (state_reg == S_DONE) && (!rsp_valid_reg || rsp.ready);
    assign commit_valid = rsp_load && is_extract && tail_reg.hit;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_xfer) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (chain[TABLE_DEPTH].valid) begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (rsp_load) begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            limit_reg     <= LIMIT_RESET;
            head_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready) begin
                limit_reg <= cfg.signo_limit;
            end
            head_reg.valid <= req_xfer;
            if (req_xfer) begin
                head_reg.opcode        <= req.opcode;
                head_reg.code          <= req.code;
                head_reg.sender        <= req.sender;
                head_reg.signo         <= req.signo;
                head_reg.payload       <= req.payload;
                head_reg.filter_enable <= req.filter_enable;
                head_reg.filter_mask   <= req.filter_mask;
                head_reg.best          <= limit_reg;
                // an insert of a free code is a no-op that reports ok
                head_reg.hit           <= (req.opcode == OP_INSERT) && (req.code == CODE_FREE);
                head_reg.hit_code      <= CODE_FREE;
                head_reg.hit_sender    <= 32'd0;
                head_reg.hit_signo     <= 6'd0;
                head_reg.hit_payload   <= 32'd0;
                head_reg.hit_count     <= 16'd0;
            end
            if (rsp_load) begin
                rsp_valid_reg <= 1'b1;
            end else if (rsp.ready) begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_SCAN) && chain[TABLE_DEPTH].valid) begin
            tail_reg     <= chain[TABLE_DEPTH];
            tail_pos_reg <= pos_chain[TABLE_DEPTH];
        end
        if (rsp_load) begin
            if (tail_reg.opcode == OP_INSERT) begin
                status_reg <= tail_reg.hit ? ST_OK : ST_FULL;
            end else if (is_extract && tail_reg.hit) begin
                status_reg <= ST_OK;
            end else begin
                status_reg <= ST_NONE;
            end
            if (is_extract && tail_reg.hit) begin
                out_code_reg    <= tail_reg.hit_code;
                out_sender_reg  <= tail_reg.hit_sender;
                out_signo_reg   <= tail_reg.hit_signo;
                out_payload_reg <= tail_reg.hit_payload;
                out_count_reg   <= tail_reg.hit_count;
            end else begin
                out_code_reg    <= CODE_FREE;
                out_sender_reg  <= 32'd0;
                out_signo_reg   <= 6'd0;
                out_payload_reg <= 32'd0;
                out_count_reg   <= 16'd0;
            end
        end
    end

    assign chain[0]     = head_reg;
    assign pos_chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            cst_cell #(
                .TABLE_DEPTH (TABLE_DEPTH),
                .CELL_INDEX  (g),
                .IDX_W       (IDX_W)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .scan_in      (chain[g]),
                .pos_in       (pos_chain[g]),
                .scan_out     (chain[g+1]),
                .pos_out      (pos_chain[g+1]),
                .commit_valid (commit_valid),
                .commit_pos   (tail_pos_reg)
            );
        end
        for (g = 0; g <= TABLE_DEPTH; g++) begin : g_live
            assign live[g] = chain[g].valid;
        end
    endgenerate

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.out_code    = out_code_reg;
    assign rsp.out_sender  = out_sender_reg;
    assign rsp.out_signo   = out_signo_reg;
    assign rsp.out_payload = out_payload_reg;
    assign rsp.out_count   = out_count_reg;

`ifndef SYNTHESIS
    a_one_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(live))
        else $error("more than one scan record in the chain");

    a_head_follows_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer |=> head_reg.valid)
        else $error("accepted request did not enter the chain");

    a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chain[TABLE_DEPTH].valid |-> (state_reg == S_SCAN))
        else $error("scan left the chain outside the scan state");

    a_commit_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        commit_valid |=> (state_reg == S_IDLE) && rsp_valid_reg)
        else $error("retire without a delivered result");
`endif

endmodule
